[src/mgm_pkg.sv]
// Shared types, constants and the dB-to-gain table of the multichannel gain mixer.
// No dependencies; the top level and the cell refer to it by scoped names.
`default_nettype none
package mgm_pkg;

    localparam int NUM_CH     = 8;
    localparam int SPC        = 4096;
    localparam int ADDR_W     = 12;
    localparam int POS_W      = 13;
    localparam int SAMPLE_W   = 24;
    localparam int GAIN_W     = 25;
    localparam int CONTRIB_W  = 29;
    localparam int SUM_W      = 30;

    localparam logic signed [SAMPLE_W-1:0] Q23_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] Q23_MIN = 24'sh800000;

    // Configuration register indexes
    localparam logic [7:0] CFG_GAIN_DB   = 8'd0;
    localparam logic [7:0] CFG_MONO_MASK = 8'd1;
    localparam logic [7:0] CFG_LEN_LOWER = 8'd2;
    localparam logic [7:0] CFG_LEN_UPPER = 8'd3;

    // Item kinds carried in tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_MIX  = 1'b1;

    typedef logic [GAIN_W-1:0] t_gain_tab [256];
    typedef logic [63:0]       t_root_tab [20];

    // 10^(r/20) * 10^10, rounded
    localparam t_root_tab ROOT_TAB = '{
        64'd10000000000, 64'd11220184543, 64'd12589254118, 64'd14125375446,
        64'd15848931925, 64'd17782794100, 64'd19952623150, 64'd22387211386,
        64'd25118864315, 64'd28183829313, 64'd31622776602, 64'd35481338923,
        64'd39810717055, 64'd44668359215, 64'd50118723363, 64'd56234132519,
        64'd63095734448, 64'd70794578438, 64'd79432823472, 64'd89125093813
    };

    // Load item written into one channel store
    typedef struct packed {
        logic                       en;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] data;
    } t_load;

    // Running mix handed from cell to cell
    typedef struct packed {
        logic                       vld;
        logic signed [SAMPLE_W-1:0] sum;
        logic [NUM_CH-1:0]          mask;
    } t_link;

    // Build the Q5.20 gain for every raw dB byte (clamped to -96..+24)
    function automatic t_gain_tab gain_tab_init();
        t_gain_tab   tab;
        int          db;
        int          q;
        int          r;
        logic [63:0] x;
        logic [63:0] g;
        for (int i = 0; i < 256; i++) begin
            db = (i >= 128) ? i - 256 : i;
            if (db < -96) db = -96;
            if (db > 24) db = 24;
            r = db + 100;
            q = 0;
            while (r >= 20) begin
                r = r - 20;
                q = q + 1;
            end
            x = ROOT_TAB[r] << 20;
            case (q)
                0: g = (x + 64'd500000000000000) / 64'd1000000000000000;
                1: g = (x + 64'd50000000000000) / 64'd100000000000000;
                2: g = (x + 64'd5000000000000) / 64'd10000000000000;
                3: g = (x + 64'd500000000000) / 64'd1000000000000;
                4: g = (x + 64'd50000000000) / 64'd100000000000;
                5: g = (x + 64'd5000000000) / 64'd10000000000;
                default: g = (x + 64'd500000000) / 64'd1000000000;
            endcase
            tab[i] = g[GAIN_W-1:0];
        end
        return tab;
    endfunction

    localparam t_gain_tab GAIN_TAB = gain_tab_init();

endpackage
`default_nettype wire

[src/multichannel_gain_mixer_top.sv]
// Multichannel gain mixer top level: stream ports, configuration registers and the cell chain.
// Depends on mgm_pkg, mgm_cell and mgm_ram.
//
// A load item writes one sample into a channel store and leaves the block free for the
// next item. A mix item passes through these steps on its way to the output register.
// The store reads and position updates in every cell happen at the accepting edge. Then
// come the gain multiply in every cell and a registered hand-over in each cell as the
// running sum passes down the chain of eight cells. Next the finished sum is flagged, and
// then it moves into the output register. A new item is accepted in the cycle after the mix
// result has moved into the output register. A mix item therefore occupies the block until
// its result has moved, which is delayed while an earlier result waits for m_axis_tready.
// Configuration writes are accepted in any cycle and must be made only while the block is
// idle.
`default_nettype none
module multichannel_gain_mixer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input items
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,  // track[2:0], address[14:3], sample_value[38:15],
                                            // prior_value[62:39], odd_slot[63]
    input  wire logic [0:0]  s_axis_tuser,  // operation[0]
    // Result items
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,  // mixed_sample[23:0], active_mask[31:24]
    // Configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    logic [63:0]                r_gain_db;
    logic [mgm_pkg::NUM_CH-1:0] r_mono;
    logic [51:0]                r_len_lo;
    logic [51:0]                r_len_hi;
    logic                       r_busy;
    logic                       r_l0;
    logic                       r_l1;
    logic                       r_pend;
    logic signed [mgm_pkg::SAMPLE_W-1:0] r_prior;

    logic                       w_acc;
    logic                       w_mix;
    logic                       w_load;
    logic                       w_move;
    logic [2:0]                 w_track;
    mgm_pkg::t_link             w_link [mgm_pkg::NUM_CH+1];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_busy;
    assign w_acc   = s_axis_tvalid && s_axis_tready;
    assign w_mix   = w_acc && (s_axis_tuser[0] == mgm_pkg::OP_MIX);
    assign w_load  = w_acc && (s_axis_tuser[0] == mgm_pkg::OP_LOAD);
    assign w_track = s_axis_tdata[2:0];
    assign w_move  = r_pend && (!m_axis_tvalid || m_axis_tready);

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_db <= '0;
            r_mono    <= '0;
            r_len_lo  <= '0;
            r_len_hi  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mgm_pkg::CFG_GAIN_DB:   r_gain_db <= i_cfg_data;
                mgm_pkg::CFG_MONO_MASK: r_mono    <= i_cfg_data[7:0];
                mgm_pkg::CFG_LEN_LOWER: r_len_lo  <= i_cfg_data[51:0];
                mgm_pkg::CFG_LEN_UPPER: r_len_hi  <= i_cfg_data[51:0];
                default: ;
            endcase
        end
    end

    // Track the mix in flight and launch the running sum into the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_l0   <= 1'b0;
            r_l1   <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_l0 <= w_mix;
            r_l1 <= r_l0;
            if (w_mix) begin
                r_busy <= 1'b1;
            end else if (w_move) begin
                r_busy <= 1'b0;
            end
            if (w_link[mgm_pkg::NUM_CH].vld) begin
                r_pend <= 1'b1;
            end else if (w_move) begin
                r_pend <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mix) begin
            r_prior <= $signed(s_axis_tdata[62:39]);
        end
    end

    assign w_link[0].vld  = r_l1;
    assign w_link[0].sum  = r_prior;
    assign w_link[0].mask = '0;

    // Row of channel cells
    for (genvar c = 0; c < mgm_pkg::NUM_CH; c++) begin : g_cell
        mgm_pkg::t_load             w_ld;
        logic [mgm_pkg::POS_W-1:0]  w_len;

        assign w_ld.en   = w_load && (w_track == 3'(c));
        assign w_ld.addr = s_axis_tdata[14:3];
        assign w_ld.data = $signed(s_axis_tdata[38:15]);
        if (c < 4) begin : g_lo
            assign w_len = r_len_lo[13*c +: 13];
        end else begin : g_hi
            assign w_len = r_len_hi[13*(c-4) +: 13];
        end

        mgm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_start   (w_mix),
            .i_odd     (s_axis_tdata[63]),
            .i_load    (w_ld),
            .i_gain_db (r_gain_db[8*c +: 8]),
            .i_mono    (r_mono[c]),
            .i_len     (w_len),
            .i_bit     (mgm_pkg::NUM_CH'(1) << c),
            .i_link    (w_link[c]),
            .o_link    (w_link[c+1])
        );
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_move) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            m_axis_tdata <= {w_link[mgm_pkg::NUM_CH].mask, w_link[mgm_pkg::NUM_CH].sum};
        end
    end

    // A finished mix waits only while a mix is still in flight
    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_busy)
        else $error("finished mix pending without a mix in flight");

    // A mix blocks further items until its result moves out
    a_mix_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mix |=> (r_busy && !s_axis_tready))
        else $error("mix accepted but block not busy");

    // A result appears only from a finished mix
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_pend))
        else $error("result without a finished mix");

    // The chain carries a sum only while a mix is in flight
    a_chain_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_link[mgm_pkg::NUM_CH].vld |-> r_busy)
        else $error("chain output outside a mix");

endmodule
`default_nettype wire

[src/mgm_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mgm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one entry, register one read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

[src/mgm_cell.sv]
// One channel cell: sample store, read position, gain multiply and one saturating add.
// Depends on mgm_pkg and mgm_ram.
`default_nettype none
module mgm_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,   // mix item accepted
    input  wire logic                        i_odd,
    input  wire mgm_pkg::t_load              i_load,
    input  wire logic [7:0]                  i_gain_db,
    input  wire logic                        i_mono,
    input  wire logic [mgm_pkg::POS_W-1:0]   i_len,
    input  wire logic [mgm_pkg::NUM_CH-1:0]  i_bit,
    input  wire mgm_pkg::t_link              i_link,
    output mgm_pkg::t_link                   o_link
);

    logic [mgm_pkg::POS_W-1:0]           r_pos;
    logic                                r_active;
    logic                                r_beyond;
    logic                                r_go;
    logic [mgm_pkg::GAIN_W-1:0]          r_gain;
    logic signed [mgm_pkg::CONTRIB_W-1:0] r_contrib;
    logic [mgm_pkg::SAMPLE_W-1:0]        w_rd_data;
    logic                                w_active;
    logic signed [mgm_pkg::SAMPLE_W-1:0] w_sample;
    logic signed [mgm_pkg::SAMPLE_W+mgm_pkg::GAIN_W-1:0] w_prod;
    logic signed [mgm_pkg::SUM_W-1:0]    w_sum;
    logic signed [mgm_pkg::SAMPLE_W-1:0] w_sat;

    mgm_ram #(
        .WIDTH (mgm_pkg::SAMPLE_W),
        .DEPTH (mgm_pkg::SPC)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_load.en),
        .i_wr_addr (i_load.addr),
        .i_wr_data (i_load.data),
        .i_rd_addr (r_pos[mgm_pkg::ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    assign w_active = (r_pos < i_len);

    // Sample position state; on a mix below i_len, step the position (mono: odd only)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_go  <= 1'b0;
        end else begin
            r_go <= i_start;
            if (i_start && w_active && (!i_mono || i_odd)) begin
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_active <= w_active;
            r_beyond <= r_pos[mgm_pkg::POS_W-1];
            r_gain   <= mgm_pkg::GAIN_TAB[i_gain_db];
        end
    end

    // Multiply the sample by the gain and floor to Q6.23
    assign w_sample = r_beyond ? '0 : $signed(w_rd_data);
    assign w_prod   = w_sample * $signed({1'b0, r_gain[mgm_pkg::GAIN_W-2:0]});

    always_ff @(posedge i_clk) begin
        if (r_go) begin
            r_contrib <= mgm_pkg::CONTRIB_W'(w_prod >>> 20);
        end
    end

    // Add the contribution and saturate
    always_comb begin
        w_sum = mgm_pkg::SUM_W'(i_link.sum);
        if (r_active) begin
            w_sum = w_sum + mgm_pkg::SUM_W'(r_contrib);
        end
        if (w_sum > mgm_pkg::SUM_W'(mgm_pkg::Q23_MAX)) begin
            w_sat = mgm_pkg::Q23_MAX;
        end else if (w_sum < mgm_pkg::SUM_W'(mgm_pkg::Q23_MIN)) begin
            w_sat = mgm_pkg::Q23_MIN;
        end else begin
            w_sat = w_sum[mgm_pkg::SAMPLE_W-1:0];
        end
    end

    // Hand the running mix to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_link.vld <= 1'b0;
        end else begin
            o_link.vld <= i_link.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_link.vld) begin
            o_link.sum  <= w_sat;
            o_link.mask <= i_link.mask | (r_active ? i_bit : '0);
        end
    end

endmodule
`default_nettype wire
